@@ design/cffa_pkg.sv @@
package cffa_pkg;

  // fixed field widths of the request and response channels
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned STATUS_W = 2;
  // a rounded-up word count plus the header word fits one bit above the byte count
  localparam int unsigned NEED_W   = SIZE_W + 1;

  localparam int unsigned ARENA_WORDS_DEF    = 1024;
  localparam int unsigned BYTES_PER_WORD_DEF = 4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WALK_P,
    S_WALK_Q,
    S_SPLIT,
    S_FREE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] data_index;
    status_e           status;
  } rsp_t;

endpackage

@@ design/cffa_chan_if.sv @@
interface cffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [cffa_pkg::SIZE_W-1:0]   size_bytes;
  logic [cffa_pkg::ADDR_W-1:0]   block_addr;

  modport source (output valid, output op, output size_bytes, output block_addr, input ready);
  modport sink   (input valid, input op, input size_bytes, input block_addr, output ready);
endinterface

interface cffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [cffa_pkg::ADDR_W-1:0]   data_index;
  logic [cffa_pkg::STATUS_W-1:0] status;

  modport source (output valid, output ok, output data_index, output status, input ready);
  modport sink   (input valid, input ok, input data_index, input status, output ready);
endinterface

@@ design/cffa_ram.sv @@
module cffa_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cffa_need.sv @@
module cffa_need #(
  parameter int unsigned BYTES_PER_WORD = cffa_pkg::BYTES_PER_WORD_DEF
) (
  input  logic [cffa_pkg::SIZE_W-1:0] size_i,
  output logic [cffa_pkg::NEED_W-1:0] need_o
);

  localparam int unsigned NW          = cffa_pkg::NEED_W;
  // reciprocal of the word size, exact for every biased byte count below 2**NW
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (32'd1 << RECIP_SHIFT) / BYTES_PER_WORD + 1;
  localparam int unsigned MW          = RECIP_SHIFT + 1;
  localparam int unsigned PW          = NW + MW;

  logic [NW-1:0] biased;
  logic [PW-1:0] prod;

  assign biased = NW'(size_i) + NW'(BYTES_PER_WORD - 1);
  assign prod   = PW'(biased) * PW'(RECIP);
  // whole words plus the header word
  assign need_o = NW'(prod >> RECIP_SHIFT) + NW'(1);

endmodule

@@ design/cffa_walk.sv @@
module cffa_walk #(
  parameter int unsigned ARENA_WORDS    = cffa_pkg::ARENA_WORDS_DEF,
  parameter int unsigned BYTES_PER_WORD = cffa_pkg::BYTES_PER_WORD_DEF,
  localparam int unsigned AW            = $clog2(ARENA_WORDS),
  localparam int unsigned WW            = AW + 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  cffa_pkg::req_t req_i,
  input  logic           slot_free_i,
  output logic           req_ready_o,
  output logic           done_o,
  output cffa_pkg::rsp_t rsp_o,
  output logic           ram_we_o,
  output logic [AW-1:0]  ram_waddr_o,
  output logic [WW-1:0]  ram_wdata_o,
  output logic [AW-1:0]  ram_raddr_o,
  input  logic [WW-1:0]  ram_rdata_i
);

  localparam int unsigned NW   = cffa_pkg::NEED_W;
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned CW   = ((AW > NW) ? AW : NW) + 1;
  localparam int unsigned BW   = ((AW > cffa_pkg::ADDR_W) ? AW : cffa_pkg::ADDR_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(ARENA_WORDS - 1);

  function automatic logic [AW-1:0] next_of(input logic [WW-1:0] w);
    logic [AW-1:0] idx;
    idx = w[WW-1:1];
    return ({1'b0, idx} < SW'(ARENA_WORDS)) ? idx : LAST;
  endfunction

  cffa_pkg::state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] rover_q, rover_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW-1:0] q_q, q_d;
  logic [WW-1:0] wp_q, wp_d;
  logic [SW-1:0] steps_q, steps_d;
  logic          wrapped_q, wrapped_d;
  logic [NW-1:0] need_q, need_d;
  logic [AW-1:0] faddr_q, faddr_d;
  logic [AW-1:0] split_q, split_d;
  logic          fwd_q, fwd_d;
  logic [WW-1:0] fwd_data_q;

  logic [NW-1:0] need_calc;
  logic [WW-1:0] rd;
  logic [AW-1:0] rd_next;
  logic          fit;
  logic [CW-1:0] gap;
  logic [CW-1:0] split_sum;
  logic [CW-1:0] idx_sum;
  logic [BW-1:0] ba_ext;
  logic [BW-1:0] ba_m1;
  logic          ba_ok;
  logic          do_adv;
  logic [AW-1:0] adv_new;

  cffa_need #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_need (
    .size_i(req_i.size_bytes),
    .need_o(need_calc)
  );

  // a read that hits the word written in the same cycle sees the new value
  assign rd        = fwd_q ? fwd_data_q : ram_rdata_i;
  assign rd_next   = next_of(rd);
  assign gap       = CW'(q_q) - CW'(p_q);
  assign fit       = (q_q > p_q) && (gap >= CW'(need_q));
  assign split_sum = CW'(p_q) + CW'(need_q);
  assign idx_sum   = CW'(p_q) + CW'(1);
  assign ba_ext    = BW'(req_i.block_addr);
  assign ba_m1     = ba_ext - BW'(1);
  assign ba_ok     = (ba_ext != '0) && (ba_ext < BW'(ARENA_WORDS - 1));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rover_d     = rover_q;
    p_d         = p_q;
    q_d         = q_q;
    wp_d        = wp_q;
    steps_d     = steps_q;
    wrapped_d   = wrapped_q;
    need_d      = need_q;
    faddr_d     = faddr_q;
    split_d     = split_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_raddr_o = '0;
    req_ready_o = 1'b0;
    done_o      = 1'b0;
    rsp_o       = '{ok: 1'b0, data_index: '0, status: cffa_pkg::ST_NOSPACE};
    do_adv      = 1'b0;
    adv_new     = q_q;

    case (state_q)
      cffa_pkg::S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == '0) begin
          ram_wdata_o = {LAST, 1'b0};
        end else if (clr_q == LAST) begin
          ram_wdata_o = WW'(1);
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = cffa_pkg::S_IDLE;
        end
      end

      cffa_pkg::S_IDLE: begin
        req_ready_o = slot_free_i;
        if (req_valid_i && slot_free_i) begin
          if (req_i.op == cffa_pkg::OP_FREE) begin
            if (ba_ok) begin
              faddr_d     = ba_m1[AW-1:0];
              ram_raddr_o = ba_m1[AW-1:0];
              state_d     = cffa_pkg::S_FREE;
            end else begin
              done_o       = 1'b1;
              rsp_o.status = cffa_pkg::ST_IGNORED;
            end
          end else begin
            need_d      = need_calc;
            p_d         = rover_q;
            wrapped_d   = 1'b0;
            ram_raddr_o = rover_q;
            state_d     = cffa_pkg::S_WALK_P;
          end
        end
      end

      cffa_pkg::S_FREE: begin
        ram_we_o     = 1'b1;
        ram_waddr_o  = faddr_q;
        ram_wdata_o  = {rd[WW-1:1], 1'b0};
        done_o       = 1'b1;
        rsp_o.ok     = 1'b1;
        rsp_o.status = cffa_pkg::ST_FREED;
        state_d      = cffa_pkg::S_IDLE;
      end

      cffa_pkg::S_WALK_P: begin
        if (!rd[0]) begin
          // free header: start merging its free successors
          wp_d        = rd;
          q_d         = rd_next;
          steps_d     = '0;
          ram_raddr_o = rd_next;
          state_d     = cffa_pkg::S_WALK_Q;
        end else begin
          do_adv  = 1'b1;
          adv_new = rd_next;
        end
      end

      cffa_pkg::S_WALK_Q: begin
        if (!rd[0] && (steps_q < SW'(ARENA_WORDS))) begin
          // absorb the free neighbor into p
          ram_we_o    = 1'b1;
          ram_waddr_o = p_q;
          ram_wdata_o = rd;
          wp_d        = rd;
          q_d         = rd_next;
          steps_d     = steps_q + SW'(1);
          ram_raddr_o = rd_next;
        end else if (fit) begin
          ram_we_o         = 1'b1;
          ram_waddr_o      = p_q;
          ram_wdata_o      = {split_sum[AW-1:0], 1'b1};
          rover_d          = split_sum[AW-1:0];
          split_d          = split_sum[AW-1:0];
          if (CW'(q_q) > split_sum) begin
            state_d = cffa_pkg::S_SPLIT;
          end else begin
            done_o           = 1'b1;
            rsp_o.ok         = 1'b1;
            rsp_o.data_index = idx_sum[cffa_pkg::ADDR_W-1:0];
            rsp_o.status     = cffa_pkg::ST_ALLOC;
            state_d          = cffa_pkg::S_IDLE;
          end
        end else begin
          do_adv  = 1'b1;
          adv_new = q_q;
        end
      end

      cffa_pkg::S_SPLIT: begin
        // remainder header takes over the old link of p
        ram_we_o         = 1'b1;
        ram_waddr_o      = split_q;
        ram_wdata_o      = wp_q;
        done_o           = 1'b1;
        rsp_o.ok         = 1'b1;
        rsp_o.data_index = idx_sum[cffa_pkg::ADDR_W-1:0];
        rsp_o.status     = cffa_pkg::ST_ALLOC;
        state_d          = cffa_pkg::S_IDLE;
      end

      default: begin
        state_d = cffa_pkg::S_IDLE;
      end
    endcase

    // step to the next header; the second backward step ends the search
    if (do_adv) begin
      if ((adv_new > p_q) || !wrapped_q) begin
        wrapped_d   = wrapped_q || !(adv_new > p_q);
        p_d         = adv_new;
        ram_raddr_o = adv_new;
        state_d     = cffa_pkg::S_WALK_P;
      end else begin
        done_o       = 1'b1;
        rsp_o.status = cffa_pkg::ST_NOSPACE;
        state_d      = cffa_pkg::S_IDLE;
      end
    end

    fwd_d = ram_we_o && (ram_waddr_o == ram_raddr_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cffa_pkg::S_CLR;
      clr_q     <= '0;
      rover_q   <= '0;
      wrapped_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rover_q   <= rover_d;
      wrapped_q <= wrapped_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    q_q        <= q_d;
    wp_q       <= wp_d;
    steps_q    <= steps_d;
    need_q     <= need_d;
    faddr_q    <= faddr_d;
    split_q    <= split_d;
    fwd_data_q <= ram_wdata_o;
  end

endmodule

@@ design/circular_first_fit_allocator.sv @@
// free: an out-of-range address is answered from idle; an in-range one reads its header and
// clears its busy bit in the free state; allocate walks the headers from the rover, merging
// free neighbors, and writes the remainder header in the split state when the block is split
// throughput: one request at a time; the next is taken once the previous response transfers
// reset: after rst_ni releases, a clearing pass writes all ARENA_WORDS words of the link
// memory; no request is taken during it
module circular_first_fit_allocator #(
  parameter int unsigned ARENA_WORDS    = cffa_pkg::ARENA_WORDS_DEF,
  parameter int unsigned BYTES_PER_WORD = cffa_pkg::BYTES_PER_WORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cffa_req_if.sink   req_i,
  cffa_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(ARENA_WORDS);
  localparam int unsigned WW = AW + 1;

  // request payload bundled for the walker
  cffa_pkg::req_t req;
  cffa_pkg::rsp_t rsp_new;
  cffa_pkg::rsp_t rsp_q;
  logic           slot_q;
  logic           done;
  logic           ready;

  // link memory port: one write and one registered read per cycle
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  assign req.op         = cffa_pkg::op_e'(req_i.op);
  assign req.size_bytes = req_i.size_bytes;
  assign req.block_addr = req_i.block_addr;
  assign req_i.ready    = ready;

  // each word holds the next header index above a busy bit
  cffa_ram #(
    .WIDTH(WW),
    .DEPTH(ARENA_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: clearing pass, header walk with merging, split and free
  cffa_walk #(
    .ARENA_WORDS   (ARENA_WORDS),
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_i      (req),
    .slot_free_i(!slot_q),
    .req_ready_o(ready),
    .done_o     (done),
    .rsp_o      (rsp_new),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  // response register; a new request waits until the previous response transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 1'b0;
    end else if (done) begin
      slot_q <= 1'b1;
    end else if (rsp_o.ready) begin
      slot_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp_new;
    end
  end

  assign rsp_o.valid      = slot_q;
  assign rsp_o.ok         = rsp_q.ok;
  assign rsp_o.data_index = rsp_q.data_index;
  assign rsp_o.status     = rsp_q.status;

  // one request in flight: an accepted request leaves ready low in the cycle after it
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // only a successful allocation carries a data index
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != cffa_pkg::ST_ALLOC) |-> rsp_o.data_index == '0)
    else $error("data index set on a non-allocation response");

  // ok follows the status code
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.ok == ((rsp_o.status == cffa_pkg::ST_ALLOC) ||
                                 (rsp_o.status == cffa_pkg::ST_FREED)))
    else $error("ok disagrees with status");

  // the walker never writes outside the arena
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ram_waddr <= AW'(ARENA_WORDS - 1))
    else $error("link write outside the arena");

endmodule
